/* rtl/vn2c_pkg.sv */
// shared constants, types and the cosine weight table for the value noise block
`timescale 1ns / 1ps

package vn2c_pkg;

    // coordinate format
    localparam int POS_W             = 32;
    localparam int FRAC_BITS         = 16;
    localparam int WEIGHT_TABLE_BITS = 10;
    localparam int TAB_SIZE          = 1 << WEIGHT_TABLE_BITS;

    // value formats
    localparam int Q_BITS   = 16;
    localparam int ONE_Q16  = 1 << Q_BITS;
    localparam int NOISE_W  = Q_BITS + 2;
    localparam int WEIGHT_W = Q_BITS + 1;

    typedef logic signed [NOISE_W-1:0] t_noise;
    typedef logic [WEIGHT_W-1:0]        t_weight;
    typedef t_weight                    t_weight_tab [TAB_SIZE];

    // corner hash constants
    localparam logic [31:0] HASH_ROW     = 32'd57;
    localparam int          HASH_XSHIFT  = 13;
    localparam logic [31:0] HASH_MUL     = 32'd60493;
    localparam logic [31:0] HASH_ADD1    = 32'd19990303;
    localparam logic [31:0] HASH_ADD2    = 32'd1376312589;
    localparam int          HASH_MSB     = 30;
    localparam int          CORNER_SHIFT = 14;

    // pipeline timing
    localparam int HASH_LAT   = 5;
    localparam int WGT_LAT    = 2;
    localparam int BLEND_LAT  = 3;
    localparam int WX_DLY     = HASH_LAT - WGT_LAT;
    localparam int WY_DLY     = WX_DLY + BLEND_LAT;
    localparam int PIPE_DEPTH = HASH_LAT + 2 * BLEND_LAT;

    // sine series used to build the weight table at elaboration
    localparam logic [63:0] PI_Q31       = 64'd6746518852;
    localparam int          SERIES_TERMS = 10;
    localparam logic [63:0] SERIES_DIV [1:SERIES_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };

    // q1.16 weight round(65536 * sin^2(pi*i/2^(bits+1))), q31 truncating series
    function automatic t_weight cos_weight(input logic [63:0] idx);
        logic [63:0] one;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] s;
        one = 64'd1 << 31;
        x   = (PI_Q31 * idx) >> (WEIGHT_TABLE_BITS + 1);
        x2  = (x * x) >> 31;
        r   = one;
        for (int k = SERIES_TERMS; k >= 1; k--) begin
            t = ((x2 * r) >> 31) / SERIES_DIV[k];
            r = (t >= one) ? 64'd0 : one - t;
        end
        s = (x * r) >> 31;
        return WEIGHT_W'((s * s + (64'd1 << 45)) >> 46);
    endfunction

    function automatic t_weight_tab build_weight_tab();
        t_weight_tab tab;
        for (int i = 0; i < TAB_SIZE; i++) begin
            tab[i] = cos_weight(64'(i));
        end
        return tab;
    endfunction

    localparam t_weight_tab WEIGHT_TAB = build_weight_tab();

endpackage

/* rtl/vn2c_hash.sv */
// pipelined integer hash of one lattice corner, mapped to a q1.16 corner value
`timescale 1ns / 1ps

module vn2c_hash import vn2c_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_cx,
    input  logic [31:0] i_cy,
    output t_noise      o_val
);

    logic [31:0] n0;
    logic [31:0] h_sum;
    logic [31:0] r_n1;
    logic [31:0] r_n2;
    logic [31:0] r_n3;
    logic [31:0] r_nn;
    logic [31:0] r_t;
    logic [31:0] r_m;
    t_noise      r_val;
    t_noise      n_val;

    // corner index fold, final add and mapping to the corner value
    always_comb begin
        n0    = i_cx + i_cy * HASH_ROW;
        h_sum = r_m + HASH_ADD2;
        n_val = NOISE_W'(ONE_Q16) - NOISE_W'(h_sum[HASH_MSB:CORNER_SHIFT]);
    end

    // at most one multiply per stage, all modulo 2^32
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n1  <= n0 ^ (n0 << HASH_XSHIFT);
            r_nn  <= r_n1 * r_n1;
            r_n2  <= r_n1;
            r_t   <= r_nn * HASH_MUL + HASH_ADD1;
            r_n3  <= r_n2;
            r_m   <= r_n3 * r_t;
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

/* rtl/vn2c_weight.sv */
// cosine weight lookup from the fraction bits, banked table with a registered select
`timescale 1ns / 1ps

module vn2c_weight import vn2c_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [POS_W-1:0] i_pos,
    output t_weight          o_w
);

    localparam int LOW_BITS  = (WEIGHT_TABLE_BITS > 8) ? 8 : WEIGHT_TABLE_BITS;
    localparam int BANK_BITS = WEIGHT_TABLE_BITS - LOW_BITS;
    localparam int BANKS     = 1 << BANK_BITS;
    localparam int HI_W      = (BANK_BITS > 0) ? BANK_BITS : 1;
    localparam int WIDE_W    = FRAC_BITS + WEIGHT_TABLE_BITS;
    localparam int SHR       = (FRAC_BITS >= WEIGHT_TABLE_BITS) ?
                               FRAC_BITS - WEIGHT_TABLE_BITS : 0;
    localparam int SHL       = (FRAC_BITS < WEIGHT_TABLE_BITS) ?
                               WEIGHT_TABLE_BITS - FRAC_BITS : 0;

    logic [WIDE_W-1:0]            frac_wide;
    logic [WEIGHT_TABLE_BITS-1:0] idx;
    logic [LOW_BITS-1:0]          idx_lo;
    logic [HI_W-1:0]              idx_hi;
    t_weight                      bank_q [BANKS];
    logic [HI_W-1:0]              r_hi;
    t_weight                      r_w;

    // fraction to table index
    always_comb begin
        frac_wide = (WIDE_W'(i_pos[FRAC_BITS-1:0]) >> SHR) << SHL;
        idx       = frac_wide[WEIGHT_TABLE_BITS-1:0];
        idx_lo    = idx[LOW_BITS-1:0];
        idx_hi    = HI_W'(idx >> LOW_BITS);
    end

    // first stage: every bank reads its entry at the low index bits
    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        localparam logic [WEIGHT_TABLE_BITS-1:0] BASE = WEIGHT_TABLE_BITS'(b << LOW_BITS);
        t_weight r_val;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val <= WEIGHT_TAB[BASE | WEIGHT_TABLE_BITS'(idx_lo)];
            end
        end
        assign bank_q[b] = r_val;
    end

    // second stage: pick the bank
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi <= idx_hi;
            r_w  <= bank_q[r_hi];
        end
    end

    assign o_w = r_w;

endmodule

/* rtl/vn2c_blend.sv */
// three stage cosine blend a + round((b - a) * w / 65536)
`timescale 1ns / 1ps

module vn2c_blend import vn2c_pkg::*; (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_noise  i_a,
    input  t_noise  i_b,
    input  t_weight i_w,
    output t_noise  o_res
);

    localparam int DIFF_W = NOISE_W + 1;
    localparam int PROD_W = DIFF_W + WEIGHT_W + 1;
    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(32'sd1 <<< (Q_BITS - 1));

    logic signed [DIFF_W-1:0]   r_d;
    logic signed [WEIGHT_W:0]   w_s;
    t_weight                    r_w;
    t_noise                     r_a1;
    t_noise                     r_a2;
    logic signed [PROD_W-1:0]   r_p;
    logic signed [PROD_W-1:0]   rnd_sum;
    logic signed [PROD_W-1:0]   rnd;
    logic signed [PROD_W-1:0]   total;
    t_noise                     r_res;

    // rounding with halves upward, result lands between a and b
    always_comb begin
        w_s     = $signed({1'b0, r_w});
        rnd_sum = r_p + HALF_LSB;
        rnd     = rnd_sum >>> Q_BITS;
        total   = rnd + PROD_W'(r_a2);
    end

    // difference, product, rounded sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d   <= DIFF_W'(i_b) - DIFF_W'(i_a);
            r_a1  <= i_a;
            r_w   <= i_w;
            r_p   <= r_d * w_s;
            r_a2  <= r_a1;
            r_res <= total[NOISE_W-1:0];
        end
    end

    assign o_res = r_res;

endmodule

/* rtl/value_noise_2d_cosine.sv */
// top level of the 2d value noise block with cosine blending
`timescale 1ns / 1ps

// Takes one point per item on the input channel (i_valid, o_stall, i_x_pos,
// i_y_pos), both coordinates unsigned 16.16, and returns one signed q1.16
// noise sample per item on the output channel (o_valid, i_stall,
// o_noise_value), in input order.
// An item is taken at a clock edge with valid high and stall low.
// From acceptance to the result showing on the output, an item passes
// 5 stages of corner hashing (three 32-bit multiplies), 3 stages for the
// x blends, 3 for the y blend, and the output register. Throughput is
// one item per cycle while o_stall is low; the pipeline advances as a whole.
// When the receiver stalls, the result held on the output stays put and the
// next finished item drops into a one-entry skid register; only once that
// skid register is full does o_stall rise and the pipeline freeze, and it
// restarts the cycle after the held result is taken.
// Up to 13 items can be inside the block at once.
// Reset (synchronous, active low) empties the pipeline, output and skid.
// The cosine weight table is constant logic and needs no loading.
module value_noise_2d_cosine import vn2c_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [POS_W-1:0] i_x_pos,
    input  logic [POS_W-1:0] i_y_pos,
    output logic             o_valid,
    input  logic             i_stall,
    output t_noise           o_noise_value
);

    logic                  en;
    logic                  out_take;
    logic [31:0]           cx0;
    logic [31:0]           cx1;
    logic [31:0]           cy0;
    logic [31:0]           cy1;
    t_noise                val_s;
    t_noise                val_t;
    t_noise                val_u;
    t_noise                val_v;
    t_weight               wx;
    t_weight               wy;
    t_weight               r_wx_dly [WX_DLY];
    t_weight               r_wy_dly [WY_DLY];
    t_noise                lo;
    t_noise                hi;
    t_noise                res;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  r_out_valid;
    logic                  r_skid_valid;
    t_noise                r_out_data;
    t_noise                r_skid_data;

    // pipeline moves whenever the skid register is free
    assign en       = !r_skid_valid;
    assign out_take = !r_out_valid || !i_stall;

    // lattice cell corners
    always_comb begin
        cx0 = i_x_pos >> FRAC_BITS;
        cy0 = i_y_pos >> FRAC_BITS;
        cx1 = cx0 + 32'd1;
        cy1 = cy0 + 32'd1;
    end

    // four corner hash lanes
    vn2c_hash u_hash_s (.i_clk(i_clk), .i_en(en), .i_cx(cx0), .i_cy(cy0), .o_val(val_s));
    vn2c_hash u_hash_t (.i_clk(i_clk), .i_en(en), .i_cx(cx1), .i_cy(cy0), .o_val(val_t));
    vn2c_hash u_hash_u (.i_clk(i_clk), .i_en(en), .i_cx(cx0), .i_cy(cy1), .o_val(val_u));
    vn2c_hash u_hash_v (.i_clk(i_clk), .i_en(en), .i_cx(cx1), .i_cy(cy1), .o_val(val_v));

    // weights for both axes
    vn2c_weight u_weight_x (.i_clk(i_clk), .i_en(en), .i_pos(i_x_pos), .o_w(wx));
    vn2c_weight u_weight_y (.i_clk(i_clk), .i_en(en), .i_pos(i_y_pos), .o_w(wy));

    // line weights up with the blend stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx_dly[0] <= wx;
            for (int k = 1; k < WX_DLY; k++) begin
                r_wx_dly[k] <= r_wx_dly[k-1];
            end
            r_wy_dly[0] <= wy;
            for (int k = 1; k < WY_DLY; k++) begin
                r_wy_dly[k] <= r_wy_dly[k-1];
            end
        end
    end

    // blend along x, then along y
    vn2c_blend u_blend_lo (
        .i_clk(i_clk), .i_en(en), .i_a(val_s), .i_b(val_t),
        .i_w(r_wx_dly[WX_DLY-1]), .o_res(lo)
    );
    vn2c_blend u_blend_hi (
        .i_clk(i_clk), .i_en(en), .i_a(val_u), .i_b(val_v),
        .i_w(r_wx_dly[WX_DLY-1]), .o_res(hi)
    );
    vn2c_blend u_blend_y (
        .i_clk(i_clk), .i_en(en), .i_a(lo), .i_b(hi),
        .i_w(r_wy_dly[WY_DLY-1]), .o_res(res)
    );

    // valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // output register and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (r_vld[PIPE_DEPTH-1]) begin
            if (out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // output and skid payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (r_vld[PIPE_DEPTH-1]) begin
            if (out_take) begin
                r_out_data <= res;
            end else begin
                r_skid_data <= res;
            end
        end
    end

    assign o_stall       = r_skid_valid;
    assign o_valid       = r_out_valid;
    assign o_noise_value = r_out_data;

endmodule

/* rtl/vn2c_checker.sv */
// port level checks for the value noise block, bound to the top level
`timescale 1ns / 1ps

module vn2c_checker import vn2c_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_stall,
    input logic   i_out_valid,
    input logic   i_out_stall,
    input t_noise i_noise_value
);

    localparam int CAP   = PIPE_DEPTH + 2;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAP);
    localparam t_noise           NOISE_MIN = NOISE_W'(1 - ONE_Q16);
    localparam t_noise           NOISE_MAX = NOISE_W'(ONE_Q16);

    logic             acc_in;
    logic             acc_out;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    // items inside the block
    always_comb begin
        acc_in  = i_in_valid && !i_in_stall;
        acc_out = i_out_valid && !i_out_stall;
        n_cnt   = r_cnt + CNT_W'(acc_in) - CNT_W'(acc_out);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // noise stays within q1.16 range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_noise_value >= NOISE_MIN && i_noise_value <= NOISE_MAX))
        else $error("noise value out of range");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_noise_value))
        else $error("stalled result changed");

    // input backpressure only starts behind a blocked output
    a_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_in_stall) |-> $past(i_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // no result without an item inside
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != '0)
        else $error("result with no item in flight");

    // occupancy bounded by pipeline, output and skid
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_CNT)
        else $error("more items in flight than storage");

endmodule

bind value_noise_2d_cosine vn2c_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_valid),
    .i_in_stall   (o_stall),
    .i_out_valid  (o_valid),
    .i_out_stall  (i_stall),
    .i_noise_value(o_noise_value)
);
